// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the equilibration scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define DES_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define DES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/des_pkg.sv =====
// Shared types and constants of the diagonal equilibration scaler.
package des_pkg;

    localparam int MAX_ORDER   = 64;
    localparam int IDX_BITS    = 6;
    localparam int CNT_BITS    = 7;
    localparam int VALUE_BITS  = 32;
    localparam int RAM_DEPTH   = 2 * MAX_ORDER;
    localparam int ADDR_BITS   = IDX_BITS + 1;

    localparam int DVD_BITS    = 64;
    localparam int DEN_BITS    = 31;
    localparam int QUO_BITS    = 49;
    localparam int RAD_BITS    = 50;
    localparam int ROOT_BITS   = 25;
    localparam int SREM_BITS   = 27;
    localparam int RATIO_BITS  = 17;
    localparam int STEP_BITS   = 7;
    localparam int DIV_STEPS   = 64;
    localparam int SQRT_STEPS  = 25;

    localparam logic [DVD_BITS-1:0] SCALE_DIVIDEND = 64'h0001_0000_0000_0000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;

    localparam int PADDR_BITS  = 3;
    localparam logic REG_MATRIX_ORDER = 1'b0;

    typedef struct packed {
        logic                         err;
        logic [CNT_BITS-1:0]          bad;
        logic [CNT_BITS-1:0]          n;
        logic signed [VALUE_BITS-1:0] min;
        logic signed [VALUE_BITS-1:0] max;
        logic                         bank;
    } job_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_BITS-1:0]  addr;
        logic [VALUE_BITS-1:0] data;
    } ram_wr_t;

endpackage

// ===== rtl/des_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module des_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/des_front.sv =====
// Front end: takes diagonal requests, stores them, tracks extremes and hands jobs on.
module des_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [des_pkg::CNT_BITS-1:0]           matrix_order,
    input  logic                                   in_valid,
    input  logic signed [des_pkg::VALUE_BITS-1:0]  diag_value,
    output logic                                   in_stall,
    output des_pkg::ram_wr_t                       wr,
    output logic                                   push,
    output des_pkg::job_t                          job,
    input  logic                                   retire
);

    logic [des_pkg::CNT_BITS-1:0]          count_reg, count_next;
    logic signed [des_pkg::VALUE_BITS-1:0] min_reg, min_next;
    logic signed [des_pkg::VALUE_BITS-1:0] max_reg, max_next;
    logic [des_pkg::CNT_BITS-1:0]          bad_reg, bad_next;
    logic                                  bank_reg, bank_next;
    logic [1:0]                            held_reg, held_next;

    logic [des_pkg::CNT_BITS-1:0] eff_order;
    logic [des_pkg::CNT_BITS-1:0] cnt1;
    logic                         accept;
    logic                         first;
    logic                         done;
    logic signed [des_pkg::VALUE_BITS-1:0] upd_min, upd_max;
    logic [des_pkg::CNT_BITS-1:0] upd_bad;

    // both banks held: wait for the back end to retire one
    assign in_stall = (held_reg == 2'd2);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (matrix_order == '0)
        begin
            eff_order = des_pkg::CNT_BITS'(1);
        end
        else if (matrix_order > des_pkg::CNT_BITS'(des_pkg::MAX_ORDER))
        begin
            eff_order = des_pkg::CNT_BITS'(des_pkg::MAX_ORDER);
        end
        else
        begin
            eff_order = matrix_order;
        end
    end

    assign first = (count_reg == '0);
    assign cnt1  = count_reg + des_pkg::CNT_BITS'(1);
    assign done  = (cnt1 >= eff_order);

    always_comb
    begin
        upd_min = (first || diag_value < min_reg) ? diag_value : min_reg;
        upd_max = (first || diag_value > max_reg) ? diag_value : max_reg;
        if (bad_reg == '0 && (diag_value[des_pkg::VALUE_BITS-1] || diag_value == '0))
        begin
            upd_bad = cnt1;
        end
        else
        begin
            upd_bad = bad_reg;
        end
    end

    assign wr.we   = accept;
    assign wr.addr = {bank_reg, count_reg[des_pkg::IDX_BITS-1:0]};
    assign wr.data = diag_value;

    assign push     = accept && done;
    assign job.err  = (upd_bad != '0);
    assign job.bad  = upd_bad;
    assign job.n    = cnt1;
    assign job.min  = upd_min;
    assign job.max  = upd_max;
    assign job.bank = bank_reg;

    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        bad_next   = bad_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (done)
            begin
                count_next = '0;
                min_next   = '0;
                max_next   = '0;
                bad_next   = '0;
                bank_next  = !bank_reg;
            end
            else
            begin
                count_next = cnt1;
                min_next   = upd_min;
                max_next   = upd_max;
                bad_next   = upd_bad;
            end
        end
        held_next = held_reg + {1'b0, push} - {1'b0, retire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            bad_reg   <= '0;
            bank_reg  <= 1'b0;
            held_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            bad_reg   <= bad_next;
            bank_reg  <= bank_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== rtl/des_queue.sv =====
// Two-entry job queue between front and back end.
`include "assert_macros.svh"

module des_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  des_pkg::job_t push_job,
    input  logic          pop,
    output des_pkg::job_t head,
    output logic          empty,
    output logic          full
);

    des_pkg::job_t                 mem_reg [des_pkg::QUEUE_DEPTH];
    logic [des_pkg::QPTR_BITS-1:0] wptr_reg, rptr_reg;
    logic [des_pkg::QPTR_BITS:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (des_pkg::QPTR_BITS+1)'(des_pkg::QUEUE_DEPTH));
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + des_pkg::QPTR_BITS'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + des_pkg::QPTR_BITS'(1);
            end
            cnt_reg <= cnt_reg + {{des_pkg::QPTR_BITS{1'b0}}, push}
                               - {{des_pkg::QPTR_BITS{1'b0}}, pop};
        end
    end

    `DES_ASSERT(a_q_no_overflow, !(push && full && !pop), "job queue overflow")
    `DES_ASSERT(a_q_no_underflow, !(pop && empty), "job queue underflow")

endmodule

// ===== rtl/des_back.sv =====
// Back end: ratio and per-element reciprocal square roots on one shared divider and root unit.
`include "assert_macros.svh"

module des_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  empty,
    input  des_pkg::job_t                         head,
    output logic                                  pop,
    output logic [des_pkg::ADDR_BITS-1:0]         raddr,
    input  logic [des_pkg::VALUE_BITS-1:0]        rdata,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [des_pkg::ROOT_BITS-1:0]         scale_factor,
    output logic [des_pkg::RATIO_BITS-1:0]        scale_ratio,
    output logic signed [des_pkg::VALUE_BITS-1:0] largest_diag,
    output logic                                  status,
    output logic [des_pkg::CNT_BITS-1:0]          bad_index,
    output logic                                  last_result,
    output logic                                  retire
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RDIV  = 8'b0000_0010,
        S_RSQRT = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_SQRT  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    des_pkg::job_t                      job_reg;
    logic [des_pkg::IDX_BITS-1:0]       k_reg;
    logic [des_pkg::STEP_BITS-1:0]      step_reg;
    logic [des_pkg::DVD_BITS-1:0]       dvd_reg;
    logic [des_pkg::DEN_BITS-1:0]       den_reg;
    logic [des_pkg::DEN_BITS-1:0]       rem_reg;
    logic [des_pkg::QUO_BITS-1:0]       quo_reg;
    logic [des_pkg::RAD_BITS-1:0]       rad_reg;
    logic [des_pkg::SREM_BITS-1:0]      srem_reg;
    logic [des_pkg::ROOT_BITS-1:0]      root_reg;
    logic [des_pkg::RATIO_BITS-1:0]     ratio_reg;
    logic [des_pkg::ROOT_BITS-1:0]      scale_reg;
    logic [des_pkg::RATIO_BITS-1:0]     oratio_reg;
    logic signed [des_pkg::VALUE_BITS-1:0] largest_reg;
    logic                               status_reg;
    logic [des_pkg::CNT_BITS-1:0]       bad_reg;
    logic                               last_reg;

    // restoring divider, one quotient bit a cycle
    logic [des_pkg::DEN_BITS:0]     div_shift;
    logic                           div_ge;
    logic [des_pkg::DEN_BITS-1:0]   rem_step;
    // digit-by-digit root, one result bit a cycle
    logic [des_pkg::SREM_BITS+1:0]  sq_shift, sq_trial;
    logic                           sq_ge;
    logic [des_pkg::SREM_BITS-1:0]  srem_step;

    logic div_last, sqrt_last, elem_last, taken;

    assign div_shift = {rem_reg, dvd_reg[des_pkg::DVD_BITS-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign rem_step  = div_ge ? des_pkg::DEN_BITS'(div_shift - {1'b0, den_reg})
                              : des_pkg::DEN_BITS'(div_shift);

    assign sq_shift  = {srem_reg, rad_reg[des_pkg::RAD_BITS-1 -: 2]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge     = (sq_shift >= sq_trial);
    assign srem_step = sq_ge ? des_pkg::SREM_BITS'(sq_shift - sq_trial)
                             : des_pkg::SREM_BITS'(sq_shift);

    assign div_last  = (step_reg == des_pkg::STEP_BITS'(des_pkg::DIV_STEPS - 1));
    assign sqrt_last = (step_reg == des_pkg::STEP_BITS'(des_pkg::SQRT_STEPS - 1));
    assign elem_last = ({1'b0, k_reg} == job_reg.n - des_pkg::CNT_BITS'(1));

    assign out_valid    = (state_reg == S_OUT);
    assign taken        = out_valid && !out_stall;
    assign retire       = taken && last_reg;
    assign pop          = (state_reg == S_IDLE) && !empty;
    assign raddr        = {job_reg.bank, k_reg};
    assign scale_factor = scale_reg;
    assign scale_ratio  = oratio_reg;
    assign largest_diag = largest_reg;
    assign status       = status_reg;
    assign bad_index    = bad_reg;
    assign last_result  = last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    state_next = head.err ? S_OUT : S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (div_last)
                begin
                    state_next = S_RSQRT;
                end
            end
            S_RSQRT:
            begin
                if (sqrt_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_WAIT;
            S_WAIT:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (taken)
                begin
                    state_next = last_reg ? S_IDLE : S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg  <= head;
                k_reg    <= '0;
                step_reg <= '0;
                // min << 32 over max; both positive when no error
                dvd_reg  <= {head.min, {(des_pkg::DVD_BITS - des_pkg::VALUE_BITS){1'b0}}};
                den_reg  <= head.max[des_pkg::DEN_BITS-1:0];
                rem_reg  <= '0;
                quo_reg  <= '0;
                scale_reg   <= '0;
                oratio_reg  <= '0;
                largest_reg <= head.max;
                status_reg  <= 1'b1;
                bad_reg     <= head.bad;
                last_reg    <= 1'b1;
            end
            S_RDIV, S_DIV:
            begin
                dvd_reg  <= {dvd_reg[des_pkg::DVD_BITS-2:0], 1'b0};
                rem_reg  <= rem_step;
                quo_reg  <= {quo_reg[des_pkg::QUO_BITS-2:0], div_ge};
                step_reg <= div_last ? '0 : step_reg + des_pkg::STEP_BITS'(1);
                if (div_last)
                begin
                    rad_reg  <= {1'b0, quo_reg[des_pkg::QUO_BITS-2:0], div_ge};
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            S_RSQRT, S_SQRT:
            begin
                rad_reg  <= {rad_reg[des_pkg::RAD_BITS-3:0], 2'b00};
                srem_reg <= srem_step;
                root_reg <= {root_reg[des_pkg::ROOT_BITS-2:0], sq_ge};
                step_reg <= sqrt_last ? '0 : step_reg + des_pkg::STEP_BITS'(1);
                if (sqrt_last && state_reg == S_RSQRT)
                begin
                    ratio_reg <= des_pkg::RATIO_BITS'({root_reg[des_pkg::ROOT_BITS-2:0], sq_ge});
                end
                if (sqrt_last && state_reg == S_SQRT)
                begin
                    scale_reg   <= {root_reg[des_pkg::ROOT_BITS-2:0], sq_ge};
                    oratio_reg  <= ratio_reg;
                    largest_reg <= job_reg.max;
                    status_reg  <= 1'b0;
                    bad_reg     <= '0;
                    last_reg    <= elem_last;
                end
            end
            S_READ:
            begin
                step_reg <= '0;
            end
            S_WAIT:
            begin
                dvd_reg <= des_pkg::SCALE_DIVIDEND;
                den_reg <= rdata[des_pkg::DEN_BITS-1:0];
                rem_reg <= '0;
                quo_reg <= '0;
            end
            S_OUT:
            begin
                if (taken && !last_reg)
                begin
                    k_reg <= k_reg + des_pkg::IDX_BITS'(1);
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

    `DES_ASSERT(a_err_is_last, !(out_valid && status) || last_result,
        "error result not marked last")
    `DES_ASSERT_NEXT(a_retire_idle, retire, state_reg == S_IDLE,
        "back end not idle after final result")

endmodule

// ===== rtl/diagonal_equilibration_scaler.sv =====
// Top level of the diagonal equilibration scaler.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  in       | in_valid / in_stall   | diag_value
//  out      | out_valid / out_stall | scale_factor scale_ratio largest_diag
//           |                       | status bad_index last_result
//  cfg      | APB psel/penable      | matrix_order at byte address 0
//
// Loading: one diagonal request per cycle into a two-bank store, so the next
// matrix loads while the back end still works on the previous one; the front
// stalls only when both banks are held by unfinished matrices.
// Results: once per matrix the ratio runs on the 64-step divider and 25-step
// root; each element then does a RAM read, the same divider and root, and an
// output that waits out stalls. Error matrix: single result in the cycle after dequeue.
// Reset is asynchronous, active low; it clears control state and sets the order
// to 1. No clearing pass: only entries written for the current matrix are read.
module diagonal_equilibration_scaler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [des_pkg::PADDR_BITS-1:0]        paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [des_pkg::VALUE_BITS-1:0] diag_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [des_pkg::ROOT_BITS-1:0]         scale_factor,
    output logic [des_pkg::RATIO_BITS-1:0]        scale_ratio,
    output logic signed [des_pkg::VALUE_BITS-1:0] largest_diag,
    output logic                                  status,
    output logic [des_pkg::CNT_BITS-1:0]          bad_index,
    output logic                                  last_result
);

    logic [des_pkg::CNT_BITS-1:0] order_reg;
    logic                         reg_write;

    des_pkg::ram_wr_t             wr;
    des_pkg::job_t                push_job, head;
    logic                         push, pop, empty, full, retire;
    logic [des_pkg::ADDR_BITS-1:0]  raddr;
    logic [des_pkg::VALUE_BITS-1:0] rdata;

    // register file: matrix_order at paddr[2] = 0; other addresses ignored, read as zero
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready
                       && (paddr[2] == des_pkg::REG_MATRIX_ORDER);
    assign prdata    = (paddr[2] == des_pkg::REG_MATRIX_ORDER)
                       ? {{(32 - des_pkg::CNT_BITS){1'b0}}, order_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= des_pkg::CNT_BITS'(1);
        end
        else if (reg_write)
        begin
            order_reg <= pwdata[des_pkg::CNT_BITS-1:0];
        end
    end

    des_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .matrix_order (order_reg),
        .in_valid     (in_valid),
        .diag_value   (diag_value),
        .in_stall     (in_stall),
        .wr           (wr),
        .push         (push),
        .job          (push_job),
        .retire       (retire)
    );

    // two banks of MAX_ORDER entries; bank bit is the address MSB
    des_ram #(
        .WIDTH (des_pkg::VALUE_BITS),
        .DEPTH (des_pkg::RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    des_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    des_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .raddr        (raddr),
        .rdata        (rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scale_factor (scale_factor),
        .scale_ratio  (scale_ratio),
        .largest_diag (largest_diag),
        .status       (status),
        .bad_index    (bad_index),
        .last_result  (last_result),
        .retire       (retire)
    );

endmodule

// ===== test/diagonal_equilibration_checker.sv =====
// Checker for the diagonal equilibration scaler: predicts results and compares.
module diagonal_equilibration_checker
    import des_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_BITS-1:0]         paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [VALUE_BITS-1:0]  diag_value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ROOT_BITS-1:0]          scale_factor,
    input  logic [RATIO_BITS-1:0]         scale_ratio,
    input  logic signed [VALUE_BITS-1:0]  largest_diag,
    input  logic                          status,
    input  logic [CNT_BITS-1:0]           bad_index,
    input  logic                          last_result,
    output int                            mismatches,
    output int                            pending,
    output int                            results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ROOT_BITS-1:0]         scale;
        logic [RATIO_BITS-1:0]        ratio;
        logic signed [VALUE_BITS-1:0] largest;
        logic                         err;
        logic [CNT_BITS-1:0]          bad;
        logic                         last;
    } scale_result_t;

    scale_result_t                 expected_scales[$];
    logic signed [VALUE_BITS-1:0]  diag_copy[MAX_ORDER];
    logic [CNT_BITS-1:0]           loaded;
    logic signed [VALUE_BITS-1:0]  min_seen;
    logic signed [VALUE_BITS-1:0]  max_seen;
    logic [CNT_BITS-1:0]           first_nonpos;
    logic [6:0]                    order_reg;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic absorb_diag(input logic signed [VALUE_BITS-1:0] d);
        int            eff;
        int            idx;
        int            n;
        logic [63:0]   ratio;
        scale_result_t r;
        eff = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
        idx = (loaded >= MAX_ORDER) ? MAX_ORDER - 1 : loaded;
        diag_copy[idx] = d;
        if (idx == 0)
        begin
            min_seen = d;
            max_seen = d;
        end
        else
        begin
            if (d < min_seen) min_seen = d;
            if (d > max_seen) max_seen = d;
        end
        if (d <= 0 && first_nonpos == 0)
            first_nonpos = idx + 1;
        loaded = idx + 1;
        if (loaded < eff)
            return;
        n = loaded;
        if (first_nonpos != 0)
        begin
            r = '{scale: '0, ratio: '0, largest: max_seen, err: 1'b1,
                  bad: first_nonpos, last: 1'b1};
            expected_scales.push_back(r);
        end
        else
        begin
            // min <= max and both positive, so the quotient is at most 2^32
            ratio = int_sqrt((64'(min_seen) << 32) / 64'(max_seen));
            for (int k = 0; k < n; k++)
            begin
                r.scale   = ROOT_BITS'(int_sqrt((64'd1 << 48) / 64'(diag_copy[k])));
                r.ratio   = RATIO_BITS'(ratio);
                r.largest = max_seen;
                r.err     = 1'b0;
                r.bad     = '0;
                r.last    = (k == n - 1);
                expected_scales.push_back(r);
            end
        end
        loaded = 0;
        min_seen = 0;
        max_seen = 0;
        first_nonpos = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_scales.delete();
            loaded       = 0;
            min_seen     = 0;
            max_seen     = 0;
            first_nonpos = 0;
            order_reg    = 7'd1;
            mismatches   = 0;
            results_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                scale_result_t got;
                got = '{scale: scale_factor, ratio: scale_ratio, largest: largest_diag,
                        err: status, bad: bad_index, last: last_result};
                results_seen++;
                if (expected_scales.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result %p", $time, got);
                end
                else
                begin
                    scale_result_t exp_r;
                    exp_r = expected_scales.pop_front();
                    if (got.scale !== exp_r.scale || got.ratio !== exp_r.ratio ||
                        got.largest !== exp_r.largest || got.err !== exp_r.err ||
                        got.bad !== exp_r.bad || got.last !== exp_r.last)
                    begin
                        mismatches++;
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_diag(diag_value);
            // only index 0 exists; a write at byte address 4 is dropped
            if (psel && penable && pwrite && pready && paddr == 0)
                order_reg = pwdata[6:0];
        end
        pending = expected_scales.size();
    end

endmodule

// ===== test/tb_diagonal_equilibration_scaler.sv =====
// Testbench top for the diagonal equilibration scaler: stimulus and verdict.
module tb_diagonal_equilibration_scaler;
    import des_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 30000;   // >> one 64-element matrix behind a long hold

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [PADDR_BITS-1:0]         paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [VALUE_BITS-1:0]  diag_value;
    logic                          out_valid;
    logic                          out_stall;
    logic [ROOT_BITS-1:0]          scale_factor;
    logic [RATIO_BITS-1:0]         scale_ratio;
    logic signed [VALUE_BITS-1:0]  largest_diag;
    logic                          status;
    logic [CNT_BITS-1:0]           bad_index;
    logic                          last_result;

    int   mismatches;
    int   pending;
    int   results_seen;
    int   requests_sent;
    int   matrices_sent;
    int   burst_left;
    int   idle_cycles;
    int   cur_order;
    logic hold_request;

    diagonal_equilibration_scaler i_dut (.*);

    diagonal_equilibration_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall pattern switches between free flow, random and heavy
    // back-pressure; on request it holds off for a long stretch so both
    // banks fill and the input side has to stall.
    initial
    begin
        int mode;
        mode = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall = 1'b1;
                repeat (3000) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 299) == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = $urandom_range(0, 1);
                    default: out_stall = ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic apb_write(input logic [PADDR_BITS-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Config may only change with the block drained; the back end can still
    // be finishing after the last result, so leave a margin.
    task automatic drain_and_set_order(input logic [31:0] order);
        in_valid = 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (100) @(negedge clk);
        apb_write(0, order);
        cur_order = order;
    endtask

    // One request, sent in bursts with random gaps between them.
    task automatic send_diag(input logic signed [VALUE_BITS-1:0] d);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid   = 1'b1;
        diag_value = d;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] healthy_diag();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 255);
            1:       return $urandom_range(60000, 70000);
            default: return ($urandom & 32'h7fff_ffff) | 32'h1;
        endcase
    endfunction

    initial
    begin
        int order;
        int bad_pos;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        diag_value   = '0;
        hold_request = 1'b0;
        burst_left   = 0;
        idle_cycles  = 0;
        cur_order    = 1;
        requests_sent = 0;
        matrices_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Order 1 straight after reset: scale extremes and error extremes.
        send_diag(32'sd1);
        send_diag(32'sh7fff_ffff);
        send_diag(32'sd0);
        send_diag(32'sh8000_0000);
        // Order 0 behaves as 1.
        drain_and_set_order(0);
        send_diag(32'sd65536);
        // Write beyond the register list must be ignored: order stays 127.
        drain_and_set_order(32'h7f);
        apb_write(4, 32'd5);
        drain_and_set_order(4);
        send_diag(32'sd65536);
        send_diag(32'sh7fff_ffff);
        send_diag(32'sd1);
        send_diag(32'sd300000);
        // Error matrix: first non-positive is the second request (bad_index 2), a later zero too.
        drain_and_set_order(3);
        send_diag(32'sd5);
        send_diag(-32'sd1);
        send_diag(32'sd0);
        // Order lowered mid-matrix: three loaded, order drops to 2, next
        // request completes a matrix of four.
        drain_and_set_order(5);
        send_diag(32'sd100);
        send_diag(32'sd4000);
        send_diag(32'sd9);
        drain_and_set_order(2);
        send_diag(32'sd70000);
        // Oversized order acts as the maximum.
        drain_and_set_order(127);
        for (int i = 0; i < MAX_ORDER; i++)
            send_diag(healthy_diag());
        matrices_sent = 9;

        // Long receiver hold while order-4 matrices follow each other with
        // no drain: both banks fill and the input side has to stall.
        drain_and_set_order(4);
        hold_request = 1'b1;
        for (int m = 0; m < 3; m++)
            for (int i = 0; i < 4; i++)
                send_diag(healthy_diag());
        matrices_sent = 12;

        // Random matrices, mostly small; the order is rewritten only when
        // it changes, so matrices of equal order run back to back.
        while (requests_sent < 370)
        begin
            case ($urandom_range(0, 19))
                0:               order = MAX_ORDER;
                1, 2, 3, 4, 5:   order = $urandom_range(7, 16);
                default:         order = $urandom_range(1, 6);
            endcase
            if (order != cur_order)
                drain_and_set_order(order);
            bad_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, order - 1) : -1;
            for (int i = 0; i < order; i++)
            begin
                if (i == bad_pos)
                    send_diag(($urandom_range(0, 3) == 0) ? 32'sd0 :
                              signed'($urandom | 32'h8000_0000));
                else if (bad_pos >= 0 && $urandom_range(0, 3) == 0)
                    send_diag(signed'($urandom));
                else
                    send_diag(healthy_diag());
            end
            matrices_sent++;
        end

        in_valid = 1'b0;
        wait (pending == 0);
        repeat (300) @(posedge clk);
        $display("Sent %0d diagonal requests in %0d matrices, checked %0d results.",
                 requests_sent, matrices_sent, results_seen);
        $display("Orders 0..127 written, error and valid matrices, long output hold.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/des_pkg.sv
rtl/des_ram.sv
rtl/des_front.sv
rtl/des_queue.sv
rtl/des_back.sv
rtl/diagonal_equilibration_scaler.sv
test/diagonal_equilibration_checker.sv
test/tb_diagonal_equilibration_scaler.sv
